// File: hdl/cstmp_pkg.sv
// ----------------------------------------------------------------------------
// cstmp_pkg
// Shared constants, codes and controller/datapath interface types of the
// chained sorted type map pool.
// ----------------------------------------------------------------------------
package cstmp_pkg;

	localparam int POOL_NODES     = 256;
	localparam int TYPE_COUNT     = 64;
	localparam int SLOTS_PER_NODE = 4;
	localparam int VALUE_BITS     = 32;
	localparam int CHAIN_MAX      = (TYPE_COUNT + SLOTS_PER_NODE - 1) / SLOTS_PER_NODE;

	localparam int NODE_W  = $clog2(POOL_NODES);
	localparam int LINK_W  = NODE_W + 1;
	localparam int SLOT_W  = $clog2(SLOTS_PER_NODE);
	localparam int J_W     = SLOT_W + 1;
	localparam int SADDR_W = NODE_W + SLOT_W;
	localparam int TYPE_W  = 6;
	localparam int STYPE_W = TYPE_W + 1;
	localparam int CNT_W   = $clog2(CHAIN_MAX);
	localparam int POS_W   = 7;
	localparam int ENT_W   = STYPE_W + VALUE_BITS;

	localparam logic [LINK_W-1:0]  LINK_NONE = '1;
	localparam logic [STYPE_W-1:0] TYPE_END  = STYPE_W'(TYPE_COUNT);

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_SET   = 2'd1,
		MODE_FETCH = 2'd2,
		MODE_FREE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_EXHAUSTED  = 2'd1,
		STAT_BAD_HANDLE = 2'd2,
		STAT_BAD_TYPE   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_TAKE_RD,
		OP_TAKE_FREE,
		OP_TAKE_NEW,
		OP_ALLOC_INIT,
		OP_LINK_RD,
		OP_NEXT_NODE,
		OP_SLOT_RD,
		OP_J_INC,
		OP_SET_LEN,
		OP_POS_RD,
		OP_POS_INC,
		OP_RD_NEXT,
		OP_WR_POS_INC,
		OP_WR_END_POS,
		OP_TAIL_FREE,
		OP_TAIL_UNLINK,
		OP_WR_VAL,
		OP_W_INIT,
		OP_LINK_TAIL,
		OP_LINK_NEW,
		OP_RD_WM1,
		OP_WR_W_DEC,
		OP_WR_END_N1,
		OP_FETCH_HIT,
		OP_FREE_WR,
		OP_DONE
	} dp_op_t;

	typedef enum logic [4:0] {
		CS_IDLE,
		CS_DISP,
		CS_TAKE,
		CS_TAKE_FREE,
		CS_ALLOC_INIT,
		CS_G_LRD,
		CS_G_LCHK,
		CS_G_SRD,
		CS_G_SCHK,
		CS_S_RD,
		CS_S_CHK,
		CS_R_RD,
		CS_R_WR,
		CS_R_END,
		CS_R_FT1,
		CS_R_FT2,
		CS_WR_VAL,
		CS_INS_CHK,
		CS_LINK_TAIL,
		CS_LINK_NEW,
		CS_I_RD,
		CS_I_WR,
		CS_I_VAL,
		CS_I_END,
		CS_FE_RD,
		CS_FE_CHK,
		CS_FE_LRD,
		CS_FE_LCHK,
		CS_F_RD,
		CS_F_WR,
		CS_DONE
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t  op;
		status_t st;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  handle_bad;
		logic  type_bad;
		logic  free_ok;
		logic  used_ok;
		logic  link_end;
		logic  last_page;
		logic  j_full;
		logic  slot_end;
		logic  pos_at_n;
		logic  t_eq;
		logic  t_gt;
		logic  val_zero;
		logic  rm_more;
		logic  tail_free;
		logic  n_full_page;
		logic  chain_full;
		logic  shift_more;
		logic  n1_mid;
		logic  mask_hit;
		logic  pend_v;
		logic  out_free;
	} dp_stat_t;

endpackage

// File: hdl/chained_sorted_type_map_pool_unit.sv
// ----------------------------------------------------------------------------
// chained_sorted_type_map_pool_unit
// Pool of 256 four-slot nodes holding per-handle chains of typed values.
// ----------------------------------------------------------------------------
// One item is worked on at a time; most steps are one access to the slot or
// link memory, whose read data is registered. Alloc takes and sets up one
// node, free works through the chain node by node, fetch reads slot by slot
// and hops from node to node. Set gathers the chain nodes and the tail slots,
// searches slot by slot, then shifts each moved slot. A further item is taken
// while the last result waits in the output register. No clearing pass is
// needed after reset.
module chained_sorted_type_map_pool_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic [7:0]                   handle,
	input  logic [cstmp_pkg::TYPE_W-1:0] entry_type,
	input  logic [31:0]                  entry_value,
	input  logic [63:0]                  type_mask,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [7:0]                   new_handle,
	output logic [cstmp_pkg::TYPE_W-1:0] found_type,
	output logic [31:0]                  found_value,
	output logic                         hit,
	output logic                         last
);
	import cstmp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cstmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	cstmp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.handle      (handle),
		.entry_type  (entry_type),
		.entry_value (entry_value),
		.type_mask   (type_mask),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.new_handle  (new_handle),
		.found_type  (found_type),
		.found_value (found_value),
		.hit         (hit),
		.last        (last)
	);

endmodule

// File: hdl/cstmp_ctrl.sv
// ----------------------------------------------------------------------------
// cstmp_ctrl
// Sequencer of the pool: walks each operation through its steps and issues
// one datapath command per cycle.
// ----------------------------------------------------------------------------
module cstmp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cstmp_pkg::dp_stat_t stat,
	output cstmp_pkg::dp_cmd_t  cmd
);
	import cstmp_pkg::*;

	ctrl_state_t state_q, state_n;
	status_t     st_q, st_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			st_q    <= STAT_OK;
		end else begin
			state_q <= state_n;
			st_q    <= st_n;
		end
	end

	assign in_stall = (state_q != CS_IDLE);

	always_comb begin
		state_n = state_q;
		st_n    = st_q;
		cmd.op  = OP_NOP;
		cmd.st  = st_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					st_n    = STAT_OK;
					state_n = CS_DISP;
				end
			end
			CS_DISP: begin
				if (stat.mode == MODE_ALLOC) begin
					state_n = CS_TAKE;
				end else if (stat.handle_bad) begin
					st_n    = STAT_BAD_HANDLE;
					state_n = CS_DONE;
				end else begin
					case (stat.mode)
						MODE_SET: begin
							if (stat.type_bad) begin
								st_n    = STAT_BAD_TYPE;
								state_n = CS_DONE;
							end else begin
								state_n = CS_G_LRD;
							end
						end
						MODE_FETCH: state_n = CS_FE_RD;
						default:    state_n = CS_F_RD;
					endcase
				end
			end
			CS_TAKE: begin
				if (stat.free_ok) begin
					cmd.op  = OP_TAKE_RD;
					state_n = CS_TAKE_FREE;
				end else if (stat.used_ok) begin
					cmd.op  = OP_TAKE_NEW;
					state_n = (stat.mode == MODE_ALLOC) ? CS_ALLOC_INIT : CS_LINK_TAIL;
				end else begin
					st_n    = STAT_EXHAUSTED;
					state_n = CS_DONE;
				end
			end
			CS_TAKE_FREE: begin
				cmd.op  = OP_TAKE_FREE;
				state_n = (stat.mode == MODE_ALLOC) ? CS_ALLOC_INIT : CS_LINK_TAIL;
			end
			CS_ALLOC_INIT: begin
				cmd.op  = OP_ALLOC_INIT;
				state_n = CS_DONE;
			end
			// Gather the chain nodes, then count the entries of the tail node.
			CS_G_LRD: begin
				cmd.op  = OP_LINK_RD;
				state_n = CS_G_LCHK;
			end
			CS_G_LCHK: begin
				if (stat.link_end) begin
					state_n = CS_G_SRD;
				end else if (stat.last_page) begin
					st_n    = STAT_BAD_HANDLE;
					state_n = CS_DONE;
				end else begin
					cmd.op  = OP_NEXT_NODE;
					state_n = CS_G_LRD;
				end
			end
			CS_G_SRD: begin
				if (stat.j_full) begin
					cmd.op  = OP_SET_LEN;
					state_n = CS_S_RD;
				end else begin
					cmd.op  = OP_SLOT_RD;
					state_n = CS_G_SCHK;
				end
			end
			CS_G_SCHK: begin
				if (stat.slot_end) begin
					cmd.op  = OP_SET_LEN;
					state_n = CS_S_RD;
				end else begin
					cmd.op  = OP_J_INC;
					state_n = CS_G_SRD;
				end
			end
			CS_S_RD: begin
				if (stat.pos_at_n) begin
					state_n = CS_INS_CHK;
				end else begin
					cmd.op  = OP_POS_RD;
					state_n = CS_S_CHK;
				end
			end
			CS_S_CHK: begin
				if (stat.t_eq) begin
					state_n = stat.val_zero ? CS_R_RD : CS_WR_VAL;
				end else if (stat.t_gt) begin
					state_n = CS_INS_CHK;
				end else begin
					cmd.op  = OP_POS_INC;
					state_n = CS_S_RD;
				end
			end
			CS_WR_VAL: begin
				cmd.op  = OP_WR_VAL;
				state_n = CS_DONE;
			end
			// Removal: close the gap, mark the new end, drop an emptied tail node.
			CS_R_RD: begin
				if (stat.rm_more) begin
					cmd.op  = OP_RD_NEXT;
					state_n = CS_R_WR;
				end else begin
					state_n = CS_R_END;
				end
			end
			CS_R_WR: begin
				cmd.op  = OP_WR_POS_INC;
				state_n = CS_R_RD;
			end
			CS_R_END: begin
				cmd.op  = OP_WR_END_POS;
				state_n = stat.tail_free ? CS_R_FT1 : CS_DONE;
			end
			CS_R_FT1: begin
				cmd.op  = OP_TAIL_FREE;
				state_n = CS_R_FT2;
			end
			CS_R_FT2: begin
				cmd.op  = OP_TAIL_UNLINK;
				state_n = CS_DONE;
			end
			// Insertion: grow the chain when the tail node is full, then shift up.
			CS_INS_CHK: begin
				if (stat.val_zero) begin
					state_n = CS_DONE;
				end else if (stat.n_full_page) begin
					if (stat.chain_full) begin
						st_n    = STAT_EXHAUSTED;
						state_n = CS_DONE;
					end else begin
						state_n = CS_TAKE;
					end
				end else begin
					cmd.op  = OP_W_INIT;
					state_n = CS_I_RD;
				end
			end
			CS_LINK_TAIL: begin
				cmd.op  = OP_LINK_TAIL;
				state_n = CS_LINK_NEW;
			end
			CS_LINK_NEW: begin
				cmd.op  = OP_LINK_NEW;
				state_n = CS_I_RD;
			end
			CS_I_RD: begin
				if (stat.shift_more) begin
					cmd.op  = OP_RD_WM1;
					state_n = CS_I_WR;
				end else begin
					state_n = CS_I_VAL;
				end
			end
			CS_I_WR: begin
				cmd.op  = OP_WR_W_DEC;
				state_n = CS_I_RD;
			end
			CS_I_VAL: begin
				cmd.op  = OP_WR_VAL;
				state_n = stat.n1_mid ? CS_I_END : CS_DONE;
			end
			CS_I_END: begin
				cmd.op  = OP_WR_END_N1;
				state_n = CS_DONE;
			end
			// Fetch holds one matching entry back so that the final one can
			// carry the last flag.
			CS_FE_RD: begin
				if (stat.j_full) begin
					state_n = CS_FE_LRD;
				end else begin
					cmd.op  = OP_SLOT_RD;
					state_n = CS_FE_CHK;
				end
			end
			CS_FE_CHK: begin
				if (stat.slot_end) begin
					state_n = CS_DONE;
				end else if (stat.mask_hit) begin
					if (!stat.pend_v || stat.out_free) begin
						cmd.op  = OP_FETCH_HIT;
						state_n = CS_FE_RD;
					end
				end else begin
					cmd.op  = OP_J_INC;
					state_n = CS_FE_RD;
				end
			end
			CS_FE_LRD: begin
				cmd.op  = OP_LINK_RD;
				state_n = CS_FE_LCHK;
			end
			CS_FE_LCHK: begin
				if (stat.link_end || stat.last_page) begin
					state_n = CS_DONE;
				end else begin
					cmd.op  = OP_NEXT_NODE;
					state_n = CS_FE_RD;
				end
			end
			CS_F_RD: begin
				cmd.op  = OP_LINK_RD;
				state_n = CS_F_WR;
			end
			CS_F_WR: begin
				cmd.op  = OP_FREE_WR;
				state_n = (stat.link_end || stat.last_page) ? CS_DONE : CS_F_RD;
			end
			CS_DONE: begin
				if (stat.out_free) begin
					cmd.op  = OP_DONE;
					state_n = CS_IDLE;
				end
			end
			default: begin
				state_n = CS_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/cstmp_dp.sv
// ----------------------------------------------------------------------------
// cstmp_dp
// Datapath of the pool: slot and link memories, free list, chain walk
// registers and the result register.
// ----------------------------------------------------------------------------
module cstmp_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cstmp_pkg::dp_cmd_t                cmd,
	output cstmp_pkg::dp_stat_t               stat,
	input  logic [1:0]                        mode,
	input  logic [7:0]                        handle,
	input  logic [cstmp_pkg::TYPE_W-1:0]      entry_type,
	input  logic [31:0]                       entry_value,
	input  logic [63:0]                       type_mask,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [7:0]                        new_handle,
	output logic [cstmp_pkg::TYPE_W-1:0]      found_type,
	output logic [31:0]                       found_value,
	output logic                              hit,
	output logic                              last
);
	import cstmp_pkg::*;

	logic [ENT_W-1:0]  sl_mem [SLOTS_PER_NODE*POOL_NODES];
	logic [LINK_W-1:0] lk_mem [POOL_NODES];

	logic [ENT_W-1:0]  sl_rd_q;
	logic [LINK_W-1:0] lk_rd_q;

	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] nodes_used_q;
	logic              out_valid_q;
	logic              pend_v_q;

	mode_t             mode_q;
	logic [NODE_W-1:0] handle_q;
	logic [TYPE_W-1:0] type_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [63:0]       mask_q;
	logic [NODE_W-1:0] chain_q [CHAIN_MAX];
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] take_q;
	logic [NODE_W-1:0] newh_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [J_W-1:0]    j_q;
	logic [POS_W-1:0]  n_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  w_q;
	logic [TYPE_W-1:0] pend_type_q;
	logic [VALUE_BITS-1:0] pend_val_q;

	logic [1:0]        out_status_q;
	logic [NODE_W-1:0] out_newh_q;
	logic [TYPE_W-1:0] out_type_q;
	logic [VALUE_BITS-1:0] out_val_q;
	logic              out_hit_q;
	logic              out_last_q;

	logic [5:0]         p;
	logic [CNT_W-1:0]   ci;
	logic [NODE_W-1:0]  ch;
	logic [SADDR_W-1:0] slot_pa;
	logic               sl_re, sl_we;
	logic [SADDR_W-1:0] sl_ra, sl_wa;
	logic [ENT_W-1:0]   sl_wd;
	logic               lk_re, lk_we;
	logic [NODE_W-1:0]  lk_ra, lk_wa;
	logic [LINK_W-1:0]  lk_wd;
	logic               out_free;
	logic               out_load;
	logic [STYPE_W-1:0] sl_type;

	assign sl_type  = sl_rd_q[ENT_W-1 -: STYPE_W];
	assign out_free = !out_valid_q || !out_stall;

	// Slot position to memory address through the gathered chain.
	always_comb begin
		case (cmd.op)
			OP_RD_NEXT:   p = pos_q[5:0] + 6'd1;
			OP_RD_WM1:    p = w_q[5:0] - 6'd1;
			OP_WR_W_DEC:  p = w_q[5:0];
			OP_WR_END_N1: p = n_q[5:0] + 6'd1;
			default:      p = pos_q[5:0];
		endcase
		case (cmd.op)
			OP_TAIL_FREE:                 ci = n_q[5:2];
			OP_TAIL_UNLINK, OP_LINK_TAIL: ci = n_q[5:2] - CNT_W'(1);
			default:                      ci = p[5:2];
		endcase
		ch      = chain_q[ci];
		slot_pa = {ch, p[SLOT_W-1:0]};
	end

	always_comb begin
		sl_re = 1'b0;
		sl_ra = slot_pa;
		sl_we = 1'b0;
		sl_wa = slot_pa;
		sl_wd = {TYPE_END, {VALUE_BITS{1'b0}}};
		lk_re = 1'b0;
		lk_ra = node_q;
		lk_we = 1'b0;
		lk_wa = ch;
		lk_wd = LINK_NONE;
		case (cmd.op)
			OP_SLOT_RD: begin
				sl_re = 1'b1;
				sl_ra = {node_q, j_q[SLOT_W-1:0]};
			end
			OP_POS_RD, OP_RD_NEXT, OP_RD_WM1: sl_re = 1'b1;
			OP_WR_POS_INC, OP_WR_W_DEC: begin
				sl_we = 1'b1;
				sl_wd = sl_rd_q;
			end
			OP_WR_END_POS, OP_WR_END_N1: sl_we = 1'b1;
			OP_WR_VAL: begin
				sl_we = 1'b1;
				sl_wd = {1'b0, type_q, val_q};
			end
			OP_ALLOC_INIT: begin
				sl_we = 1'b1;
				sl_wa = {take_q, {SLOT_W{1'b0}}};
				lk_we = 1'b1;
				lk_wa = take_q;
			end
			OP_TAKE_RD: begin
				lk_re = 1'b1;
				lk_ra = free_head_q[NODE_W-1:0];
			end
			OP_LINK_RD: lk_re = 1'b1;
			OP_TAIL_FREE: begin
				lk_we = 1'b1;
				lk_wd = free_head_q;
			end
			OP_TAIL_UNLINK: lk_we = 1'b1;
			OP_LINK_TAIL: begin
				lk_we = 1'b1;
				lk_wd = {1'b0, take_q};
			end
			OP_LINK_NEW: begin
				lk_we = 1'b1;
				lk_wa = take_q;
			end
			OP_FREE_WR: begin
				lk_we = 1'b1;
				lk_wa = node_q;
				lk_wd = free_head_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sl_we) begin
			sl_mem[sl_wa] <= sl_wd;
		end
		if (sl_re) begin
			sl_rd_q <= sl_mem[sl_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (lk_we) begin
			lk_mem[lk_wa] <= lk_wd;
		end
		if (lk_re) begin
			lk_rd_q <= lk_mem[lk_ra];
		end
	end

	assign out_load = (cmd.op == OP_DONE) || (cmd.op == OP_FETCH_HIT && pend_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= LINK_NONE;
			nodes_used_q <= '0;
			out_valid_q  <= 1'b0;
			pend_v_q     <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD:      pend_v_q <= 1'b0;
				OP_FETCH_HIT: pend_v_q <= 1'b1;
				OP_TAKE_FREE: free_head_q <= lk_rd_q;
				OP_TAKE_NEW:  nodes_used_q <= nodes_used_q + LINK_W'(1);
				OP_TAIL_FREE: free_head_q <= {1'b0, ch};
				OP_FREE_WR:   free_head_q <= {1'b0, node_q};
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mode_q   <= mode_t'(mode);
				handle_q <= handle;
				type_q   <= entry_type;
				val_q    <= entry_value;
				mask_q   <= type_mask;
				node_q   <= handle;
				cnt_q    <= '0;
				j_q      <= '0;
				newh_q   <= '0;
			end
			OP_TAKE_FREE: take_q <= free_head_q[NODE_W-1:0];
			OP_TAKE_NEW:  take_q <= nodes_used_q[NODE_W-1:0];
			OP_ALLOC_INIT: newh_q <= take_q;
			OP_LINK_RD:   chain_q[cnt_q] <= node_q;
			OP_NEXT_NODE: begin
				node_q <= lk_rd_q[NODE_W-1:0];
				cnt_q  <= cnt_q + CNT_W'(1);
				j_q    <= '0;
			end
			OP_J_INC: j_q <= j_q + J_W'(1);
			OP_SET_LEN: begin
				n_q   <= {1'b0, cnt_q, {SLOT_W{1'b0}}} + POS_W'(j_q);
				pos_q <= '0;
			end
			OP_POS_INC, OP_WR_POS_INC: pos_q <= pos_q + POS_W'(1);
			OP_W_INIT: w_q <= n_q;
			OP_LINK_TAIL: chain_q[n_q[5:2]] <= take_q;
			OP_LINK_NEW: w_q <= n_q;
			OP_WR_W_DEC: w_q <= w_q - POS_W'(1);
			OP_FETCH_HIT: begin
				pend_type_q <= sl_type[TYPE_W-1:0];
				pend_val_q  <= sl_rd_q[VALUE_BITS-1:0];
				j_q         <= j_q + J_W'(1);
			end
			OP_FREE_WR: begin
				node_q <= lk_rd_q[NODE_W-1:0];
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_status_q <= (cmd.op == OP_DONE) ? cmd.st : STAT_OK;
			out_newh_q   <= (cmd.op == OP_DONE) ? newh_q : '0;
			out_type_q   <= pend_v_q ? pend_type_q : '0;
			out_val_q    <= pend_v_q ? pend_val_q : '0;
			out_hit_q    <= pend_v_q;
			out_last_q   <= (cmd.op == OP_DONE);
		end
	end

	always_comb begin
		stat.mode        = mode_q;
		stat.handle_bad  = {1'b0, handle_q} >= nodes_used_q;
		stat.type_bad    = {1'b0, type_q} >= TYPE_END;
		stat.free_ok     = !free_head_q[NODE_W];
		stat.used_ok     = nodes_used_q < LINK_W'(POOL_NODES);
		stat.link_end    = lk_rd_q[NODE_W] || (lk_rd_q >= nodes_used_q);
		stat.last_page   = cnt_q == CNT_W'(CHAIN_MAX - 1);
		stat.j_full      = j_q == J_W'(SLOTS_PER_NODE);
		stat.slot_end    = sl_type >= TYPE_END;
		stat.pos_at_n    = pos_q == n_q;
		stat.t_eq        = sl_type == {1'b0, type_q};
		stat.t_gt        = sl_type > {1'b0, type_q};
		stat.val_zero    = val_q == '0;
		stat.rm_more     = (pos_q + POS_W'(1)) < n_q;
		stat.tail_free   = (n_q > POS_W'(SLOTS_PER_NODE)) && (n_q[SLOT_W-1:0] == SLOT_W'(1));
		stat.n_full_page = (n_q != '0) && (n_q[SLOT_W-1:0] == '0);
		stat.chain_full  = n_q >= POS_W'(CHAIN_MAX * SLOTS_PER_NODE);
		stat.shift_more  = w_q > pos_q;
		stat.n1_mid      = n_q[SLOT_W-1:0] != {SLOT_W{1'b1}};
		stat.mask_hit    = mask_q[sl_type[TYPE_W-1:0]];
		stat.pend_v      = pend_v_q;
		stat.out_free    = out_free;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign new_handle  = out_newh_q;
	assign found_type  = out_type_q;
	assign found_value = out_val_q;
	assign hit         = out_hit_q;
	assign last        = out_last_q;

endmodule

// File: hdl/cstmp_chk.sv
// ----------------------------------------------------------------------------
// cstmp_chk
// Port-level checks of the pool, attached to the top level.
// ----------------------------------------------------------------------------
module cstmp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [7:0]  new_handle,
	input logic        hit,
	input logic        last
);
	import cstmp_pkg::*;

	// A result still waiting is not dropped.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("pending result dropped");

	// The block is busy in the cycle after it accepts an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// Only fetched entries may be followed by more results of the same item.
	a_nonlast_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> hit)
		else $error("non-final result without an entry");

	// A fetched entry always reports success and no handle.
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> status == STAT_OK && new_handle == 8'd0)
		else $error("fetched entry with status or handle");

	// Errors end the item at once and carry nothing.
	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> last && !hit)
		else $error("error result not final");

endmodule

bind chained_sorted_type_map_pool_unit cstmp_chk u_chk (.*);

// File: test/tb_chained_sorted_type_map_pool_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chained_sorted_type_map_pool_unit
// Self-checking bench for the chained sorted type map pool. A behavioral
// copy of the pool predicts the results of every accepted item, and each
// result that leaves the block is compared field by field with the oldest
// prediction. Directed tests cover the basic operations and a chain holding
// every type; random phases follow with varied idling and output stalls.
// ----------------------------------------------------------------------------
module tb_chained_sorted_type_map_pool_unit;
	import cstmp_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [8:0] NO_LINK = 9'h1ff;

	typedef struct packed {
		status_t     status;
		logic [7:0]  new_handle;
		logic [5:0]  found_type;
		logic [31:0] found_value;
		logic        hit;
		logic        last;
	} pool_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [7:0]  handle;
	logic [5:0]  entry_type;
	logic [31:0] entry_value;
	logic [63:0] type_mask;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  new_handle;
	logic [5:0]  found_type;
	logic [31:0] found_value;
	logic        hit;
	logic        last;

	chained_sorted_type_map_pool_unit dut (.*);

	// Shadow copy of the pool.
	logic [6:0]  pool_type[1024];
	logic [31:0] pool_val[1024];
	logic [8:0]  pool_link[256];
	logic [8:0]  free_top;
	int          used_nodes;
	int          walk_nodes[CHAIN_MAX + 1];

	pool_result_t pending_results[$];
	int           live_heads[$];
	logic [7:0]   last_handle;
	int           mismatches;
	int           cycles;
	int           send_idle_pct;
	int           recv_stall_pct;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pool_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{status_t'(status), new_handle, found_type, found_value, hit, last};
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	function automatic int slot_index(int pos);
		int page;
		page = pos / SLOTS_PER_NODE;
		if (page > CHAIN_MAX)
			page = CHAIN_MAX;
		return (walk_nodes[page] % POOL_NODES) * SLOTS_PER_NODE + pos % SLOTS_PER_NODE;
	endfunction

	function automatic void move_slot(int dst, int src);
		int a, b;
		a = slot_index(dst);
		b = slot_index(src);
		pool_type[a] = pool_type[b];
		pool_val[a] = pool_val[b];
	endfunction

	function automatic void write_slot(int pos, int t, logic [31:0] v);
		int a;
		a = slot_index(pos);
		pool_type[a] = 7'(t);
		pool_val[a] = v;
	endfunction

	function automatic bit chain_ends(logic [8:0] nxt);
		return nxt == NO_LINK || nxt >= used_nodes;
	endfunction

	// Records the nodes of a chain and its entry count; fails on an overlong chain.
	function automatic bit walk_chain(int head, output int count);
		int node, i, j;
		node = head;
		count = 0;
		for (i = 0; i < CHAIN_MAX; i++) begin
			walk_nodes[i] = node;
			if (chain_ends(pool_link[node])) begin
				for (j = 0; j < SLOTS_PER_NODE; j++)
					if (pool_type[node * SLOTS_PER_NODE + j] >= TYPE_COUNT)
						break;
				count = i * SLOTS_PER_NODE + j;
				return 1'b1;
			end
			node = pool_link[node];
		end
		return 1'b0;
	endfunction

	function automatic bit grab_node(output int idx);
		idx = 0;
		if (free_top != NO_LINK && free_top < POOL_NODES) begin
			idx = free_top;
			free_top = pool_link[idx];
			return 1'b1;
		end
		if (used_nodes < POOL_NODES) begin
			idx = used_nodes++;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic status_t store_entry(int head, int t, logic [31:0] v);
		int n, i, j, k, lastp, node;
		if (!walk_chain(head, n))
			return STAT_BAD_HANDLE;
		for (i = 0; i < n; i++) begin
			if (pool_type[slot_index(i)] == t) begin
				if (v == 0) begin
					for (; i + 1 < n; i++)
						move_slot(i, i + 1);
					write_slot(i, TYPE_COUNT, '0);
					// Emptied tail node goes back to the free list.
					if (n > SLOTS_PER_NODE && (n - 1) % SLOTS_PER_NODE == 0) begin
						k = n / SLOTS_PER_NODE;
						pool_link[walk_nodes[k]] = free_top;
						free_top = 9'(walk_nodes[k]);
						pool_link[walk_nodes[k - 1]] = NO_LINK;
					end
				end else begin
					write_slot(i, t, v);
				end
				return STAT_OK;
			end
			if (pool_type[slot_index(i)] > t)
				break;
		end
		if (v == 0)
			return STAT_OK;
		if (n != 0 && n % SLOTS_PER_NODE == 0) begin
			lastp = (n - 1) / SLOTS_PER_NODE;
			if (lastp + 1 >= CHAIN_MAX)
				return STAT_EXHAUSTED;
			if (!grab_node(node))
				return STAT_EXHAUSTED;
			pool_link[walk_nodes[lastp]] = 9'(node);
			walk_nodes[lastp + 1] = node;
			pool_link[node] = NO_LINK;
		end
		for (j = n; j > i; j--)
			move_slot(j, j - 1);
		write_slot(i, t, v);
		if ((n + 1) % SLOTS_PER_NODE != 0)
			write_slot(n + 1, TYPE_COUNT, '0);
		return STAT_OK;
	endfunction

	// Works out the results of one accepted item and queues them.
	function automatic void predict_item(mode_t md, int h, int t, logic [31:0] v,
			logic [63:0] m);
		pool_result_t hits[$];
		pool_result_t res;
		int idx, node, i, j, a;
		bit done;
		res = '{STAT_OK, 8'd0, 6'd0, 32'd0, 1'b0, 1'b1};
		if (md == MODE_ALLOC) begin
			if (grab_node(idx)) begin
				pool_link[idx] = NO_LINK;
				pool_type[idx * SLOTS_PER_NODE] = TYPE_COUNT;
				res.new_handle = 8'(idx);
				live_heads.push_back(idx);
			end else begin
				res.status = STAT_EXHAUSTED;
			end
		end else if (h >= used_nodes) begin
			res.status = STAT_BAD_HANDLE;
		end else if (md == MODE_SET) begin
			// A six-bit type can never reach the type count, so no bad-type case.
			res.status = store_entry(h, t, v);
		end else if (md == MODE_FETCH) begin
			node = h;
			for (i = 0; i < CHAIN_MAX; i++) begin
				done = 1'b0;
				for (j = 0; j < SLOTS_PER_NODE; j++) begin
					a = node * SLOTS_PER_NODE + j;
					if (pool_type[a] >= TYPE_COUNT) begin
						done = 1'b1;
						break;
					end
					if (m[pool_type[a][5:0]] && hits.size() < 64)
						hits.push_back('{STAT_OK, 8'd0, pool_type[a][5:0], pool_val[a],
							1'b1, 1'b0});
				end
				if (done || chain_ends(pool_link[node]))
					break;
				node = pool_link[node];
			end
			if (hits.size() != 0) begin
				hits[hits.size() - 1].last = 1'b1;
				foreach (hits[k])
					pending_results.push_back(hits[k]);
				return;
			end
		end else begin
			node = h;
			for (i = 0; i < CHAIN_MAX; i++) begin
				idx = pool_link[node];
				pool_link[node] = free_top;
				free_top = 9'(node);
				if (chain_ends(9'(idx)))
					break;
				node = idx;
			end
			foreach (live_heads[k])
				if (live_heads[k] == h) begin
					live_heads.delete(k);
					break;
				end
		end
		last_handle = res.new_handle;
		pending_results.push_back(res);
	endfunction

	task automatic send_item(mode_t md, logic [7:0] h, logic [5:0] t, logic [31:0] v,
			logic [63:0] m);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		mode        <= md;
		handle      <= h;
		entry_type  <= t;
		entry_value <= v;
		type_mask   <= m;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(md, h, t, v, m);
	endtask

	task automatic alloc_chain();
		send_item(MODE_ALLOC, 8'($urandom), 6'($urandom), $urandom, {$urandom, $urandom});
	endtask

	task automatic test_basic_ops();
		logic [7:0] a, b;
		alloc_chain();
		a = last_handle;
		alloc_chain();
		b = last_handle;
		send_item(MODE_FETCH, a, '0, '0, '1);
		send_item(MODE_SET, a, 6'd63, 32'hffff_ffff, '0);
		send_item(MODE_SET, a, 6'd0, 32'h0000_0001, '0);
		send_item(MODE_SET, a, 6'd5, 32'h8000_0000, '0);
		send_item(MODE_SET, a, 6'd3, 32'h1234_5678, '0);
		send_item(MODE_SET, a, 6'd42, 32'hdead_beef, '0);
		send_item(MODE_SET, a, 6'd5, 32'h5555_aaaa, '0);
		send_item(MODE_SET, a, 6'd17, 32'd0, '0);
		send_item(MODE_FETCH, a, '0, '0, '1);
		send_item(MODE_FETCH, a, '0, '0, 64'h8000_0000_0000_0021);
		send_item(MODE_FETCH, a, '0, '0, '0);
		send_item(MODE_SET, a, 6'd3, 32'd0, '0);
		send_item(MODE_SET, a, 6'd42, 32'd0, '0);
		send_item(MODE_FETCH, a, '0, '0, '1);
		send_item(MODE_SET, b, 6'd9, 32'h0f0f_0f0f, '0);
		send_item(MODE_SET, 8'hff, 6'd1, 32'd7, '0);
		send_item(MODE_FETCH, 8'hff, '0, '0, '1);
		send_item(MODE_FREE, 8'hff, '0, '0, '0);
		send_item(MODE_FREE, b, '0, '0, '0);
		alloc_chain();
		send_item(MODE_FETCH, last_handle, '0, '0, '1);
	endtask

	// Fills one chain with every type, worst case for shifting and fetch length.
	task automatic test_full_chain();
		logic [7:0] h;
		alloc_chain();
		h = last_handle;
		for (int t = 63; t >= 0; t -= 2)
			send_item(MODE_SET, h, 6'(t), $urandom | 32'd1, '0);
		for (int t = 0; t < 64; t += 2)
			send_item(MODE_SET, h, 6'(t), $urandom | 32'd1, '0);
		send_item(MODE_FETCH, h, '0, '0, '1);
		send_item(MODE_SET, h, 6'd0, 32'd0, '0);
		send_item(MODE_SET, h, 6'd63, 32'd0, '0);
		send_item(MODE_SET, h, 6'd0, 32'h0bad_cafe, '0);
		send_item(MODE_FETCH, h, '0, '0, 64'haaaa_5555_f0f0_0f0f);
		send_item(MODE_FREE, h, '0, '0, '0);
	endtask

	task automatic test_random_mix(int count);
		int r, h;
		logic [63:0] m;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (live_heads.size() == 0 || r < 12) begin
				alloc_chain();
				continue;
			end
			h = live_heads[$urandom_range(live_heads.size() - 1)];
			// An occasional handle beyond the used part of the pool.
			if (used_nodes < POOL_NODES && $urandom_range(99) < 8)
				h = $urandom_range(POOL_NODES - 1, used_nodes);
			case ($urandom_range(2))
				0: m = '1;
				1: m = 64'd1 << $urandom_range(63);
				default: m = {$urandom, $urandom};
			endcase
			if (r < 65)
				send_item(MODE_SET, 8'(h), 6'($urandom_range(63)),
					($urandom_range(99) < 25) ? 32'd0 : $urandom, {$urandom, $urandom});
			else if (r < 92)
				send_item(MODE_FETCH, 8'(h), 6'($urandom), $urandom, m);
			else
				send_item(MODE_FREE, 8'(h), 6'($urandom), $urandom, m);
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		mode           = MODE_ALLOC;
		handle         = '0;
		entry_type     = '0;
		entry_value    = '0;
		type_mask      = '0;
		mismatches     = 0;
		cycles         = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		foreach (pool_type[k]) begin
			pool_type[k] = '0;
			pool_val[k] = '0;
		end
		foreach (pool_link[k])
			pool_link[k] = '0;
		foreach (walk_nodes[k])
			walk_nodes[k] = 0;
		free_top   = NO_LINK;
		used_nodes = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_full_chain();
		test_random_mix(10);
		send_idle_pct = 62;
		test_random_mix(10);
		send_idle_pct  = 0;
		recv_stall_pct = 62;
		test_random_mix(10);
		send_idle_pct  = 35;
		recv_stall_pct = 35;
		test_random_mix(10);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
